### rtl/tllc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllc_pkg
// Shared widths, coefficients, register codes and stage payload types of the
// trace log level converter.
// ----------------------------------------------------------------------------
package tllc_pkg;

  // Field widths
  localparam int unsigned IndexW  = 16;
  localparam int unsigned SampleW = 32;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned LevelW  = 18;
  localparam int unsigned ProdW   = SampleW + ScaleW;
  localparam int unsigned FracW   = 23;
  localparam int unsigned ExpW    = 8;
  localparam int unsigned LeadW   = 6;

  // Configuration channel
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRecipScale   = 3'd0,
    CfgConcatEnable = 3'd1,
    CfgJoinPoint    = 3'd2,
    CfgLowOffset    = 3'd3,
    CfgMinLevel     = 3'd4
  } cfg_reg_e;

  // Cubic coefficients and log10(2), all Q.24
  localparam logic        [19:0] C3Coef   = 20'd839867;
  localparam logic signed [23:0] C2Coef   = 24'sd2972587;
  localparam logic signed [23:0] C1Coef   = 24'sd7190379;
  localparam logic signed [23:0] ClogCoef = 24'sd5049942;

  // Exponent reported for a zero product
  localparam logic signed [ExpW-1:0] ZeroExp = -8'sd127;

  // Level limits
  localparam logic signed [LevelW-1:0] LevelMax = {1'b0, {(LevelW-1){1'b1}}};
  localparam logic signed [LevelW-1:0] LevelMin = {1'b1, {(LevelW-1){1'b0}}};

  // Register reset values
  localparam logic [ScaleW-1:0] RecipReset = 32'h0100_0000;

  typedef struct packed {
    logic [ScaleW-1:0]        recip_scale;
    logic                     concat_enable;
    logic [IndexW-1:0]        join_point;
    logic signed [LevelW-1:0] low_offset;
    logic signed [LevelW-1:0] min_level;
  } cfg_t;

  // Scaled magnitude leaving the front end
  typedef struct packed {
    logic             use_low;
    logic [ProdW-1:0] prod;
  } prod_t;

  // Normalized product: exponent and mantissa fraction
  typedef struct packed {
    logic                   use_low;
    logic [FracW-1:0]       frac;
    logic signed [ExpW-1:0] expo;
  } norm_t;

  // Level before offset and floor
  typedef struct packed {
    logic                     use_low;
    logic signed [LevelW-1:0] level;
  } lvl_t;

endpackage
`default_nettype wire

### rtl/tllc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllc interfaces
// Valid/ready channels for samples, levels and configuration writes.
// ----------------------------------------------------------------------------
interface tllc_sample_if import tllc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IndexW-1:0]         sample_index;
  logic signed [SampleW-1:0] high_sample;
  logic signed [SampleW-1:0] low_sample;

  modport source (output valid, sample_index, high_sample, low_sample, input ready);
  modport sink   (input valid, sample_index, high_sample, low_sample, output ready);
endinterface

interface tllc_level_if import tllc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [LevelW-1:0] level;

  modport source (output valid, level, input ready);
  modport sink   (input valid, level, output ready);
endinterface

interface tllc_cfg_if import tllc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/tllc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllc_front
// Two stages: channel select and magnitude, then the 32x32 scale multiply.
// ----------------------------------------------------------------------------
module tllc_front import tllc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [IndexW-1:0]         sample_index_i,
  input  logic signed [SampleW-1:0] high_sample_i,
  input  logic signed [SampleW-1:0] low_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output prod_t                     out_o
);

  logic                v1_q, v2_q;
  logic                rdy1, rdy2;
  logic                use_low_d, use_low1_q;
  logic [SampleW-1:0]  sel;
  logic [SampleW-1:0]  mag_d, mag1_q;
  logic [ProdW-1:0]    prod;
  prod_t               out_q;

  // Stage handshake
  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Position is 16 bits and the trace holds 64K samples: no wrap needed
  assign use_low_d = cfg_i.concat_enable && (sample_index_i < cfg_i.join_point);
  assign sel       = use_low_d ? low_sample_i : high_sample_i;
  // Most negative sample maps to 2^31, which still fits unsigned
  assign mag_d     = sel[SampleW-1] ? (~sel + SampleW'(1)) : sel;

  assign prod = mag1_q * cfg_i.recip_scale;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      use_low1_q <= use_low_d;
      mag1_q     <= mag_d;
    end
    if (rdy2 && v1_q) begin
      out_q.use_low <= use_low1_q;
      out_q.prod    <= prod;
    end
  end

  assign out_valid_o = v2_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

### rtl/tllc_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllc_norm
// Leading-one search over the 64-bit product in two stages (per byte, then
// across bytes), followed by the normalizing shift into exponent and fraction.
// ----------------------------------------------------------------------------
module tllc_norm import tllc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  prod_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output norm_t out_o
);

  localparam int unsigned NumGrp = ProdW / 8;
  localparam int unsigned GrpW   = $clog2(NumGrp);

  logic                 v1_q, v2_q;
  logic                 rdy1, rdy2;
  logic [NumGrp-1:0]    nz_d, nz_q;
  logic [2:0]           pos_d [NumGrp];
  logic [2:0]           pos_q [NumGrp];
  prod_t                p_q;
  logic [GrpW-1:0]      gsel;
  logic [LeadW-1:0]     lead;
  logic [ProdW-1:0]     shifted;
  norm_t                n_d, out_q;

  // Stage handshake
  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Byte-wise leading one
  always_comb begin
    for (int g = 0; g < NumGrp; g++) begin
      nz_d[g]  = |in_i.prod[8*g +: 8];
      pos_d[g] = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (in_i.prod[8*g+i]) pos_d[g] = 3'(i);
      end
    end
  end

  // Highest nonzero byte, then shift the leading one to the top bit
  always_comb begin
    gsel = '0;
    for (int g = 0; g < NumGrp; g++) begin
      if (nz_q[g]) gsel = GrpW'(g);
    end
    lead      = {gsel, pos_q[gsel]};
    shifted   = p_q.prod << (~lead);
    n_d.use_low = p_q.use_low;
    if (nz_q == '0) begin
      n_d.frac = '0;
      n_d.expo = ZeroExp;
    end else begin
      n_d.frac = shifted[ProdW-2 -: FracW];
      n_d.expo = $signed({2'b00, lead}) - 8'sd24;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      p_q  <= in_i;
      nz_q <= nz_d;
      for (int g = 0; g < NumGrp; g++) pos_q[g] <= pos_d[g];
    end
    if (rdy2 && v1_q) out_q <= n_d;
  end

  assign out_valid_o = v2_q;
  assign out_o       = out_q;

endmodule
`default_nettype wire

### rtl/tllc_poly.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllc_poly
// Cubic log10 correction in Horner form, one multiply per stage, then the
// exponent term, the factor of 5 and rounding to 8 fraction bits.
// ----------------------------------------------------------------------------
module tllc_poly import tllc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  norm_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output lvl_t  out_o
);

  logic [3:0] v_q;
  logic [3:0] rdy;

  // Stage 1: C3*m and e*log10(2)
  logic [42:0]              a_full;
  logic signed [31:0]       ec_full;
  logic                     s1_use_low_q;
  logic [FracW-1:0]         s1_frac_q;
  logic signed [31:0]       s1_ec_q;
  logic [19:0]              s1_ahi_q;

  // Stage 2: u = floor(t*m / 2^23)
  logic signed [23:0]       t;
  logic signed [47:0]       u_full;
  logic                     s2_use_low_q;
  logic [FracW-1:0]         s2_frac_q;
  logic signed [31:0]       s2_ec_q;
  logic signed [24:0]       s2_u_q;

  // Stage 3: y = floor(q*m / 2^23)
  logic signed [24:0]       q;
  logic [46:0]              y_full;
  logic                     s3_use_low_q;
  logic signed [31:0]       s3_ec_q;
  logic [FracW-1:0]         s3_y_q;

  // Stage 4: level = floor((5*L + 2^15) / 2^16)
  logic signed [32:0]       lsum;
  logic signed [35:0]       scaled;
  lvl_t                     out_q;

  // Stage handshake
  always_comb begin
    rdy[3] = !v_q[3] || out_ready_i;
    for (int k = 2; k >= 0; k--) rdy[k] = !v_q[k] || rdy[k+1];
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign a_full  = C3Coef * in_i.frac;
  assign ec_full = in_i.expo * ClogCoef;

  // t is always negative, u lands in [-C2, 0]
  assign t      = $signed({4'b0000, s1_ahi_q}) - C2Coef;
  assign u_full = t * $signed({1'b0, s1_frac_q});

  assign q      = 25'(C1Coef) + s2_u_q;
  assign y_full = q[23:0] * s2_frac_q;

  assign lsum   = 33'(s3_ec_q) + $signed({10'b0, s3_y_q});
  assign scaled = (36'(lsum) <<< 2) + 36'(lsum) + 36'sd32768;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      s1_use_low_q <= in_i.use_low;
      s1_frac_q    <= in_i.frac;
      s1_ec_q      <= ec_full;
      s1_ahi_q     <= a_full[42:23];
    end
    if (rdy[1] && v_q[0]) begin
      s2_use_low_q <= s1_use_low_q;
      s2_frac_q    <= s1_frac_q;
      s2_ec_q      <= s1_ec_q;
      s2_u_q       <= u_full[47:23];
    end
    if (rdy[2] && v_q[1]) begin
      s3_use_low_q <= s2_use_low_q;
      s3_ec_q      <= s2_ec_q;
      s3_y_q       <= y_full[45:23];
    end
    if (rdy[3] && v_q[2]) begin
      out_q.use_low <= s3_use_low_q;
      out_q.level   <= scaled[33:16];
    end
  end

  assign out_valid_o = v_q[3];
  assign out_o       = out_q;

endmodule
`default_nettype wire

### rtl/trace_log_level_converter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trace_log_level_converter_top
// Converts trace samples into 5*log10 levels with 8 fraction bits.
// ----------------------------------------------------------------------------
// The converter takes one sample beat per clock while the output is not stalled
// and returns one level beat per sample, in order. The pipeline has two front
// stages (channel select and magnitude, then the 32x32 scale multiply), two
// stages of leading-one search and normalization, four stages for the cubic
// and the level arithmetic (one Horner multiply in each of the first three),
// and the output register that applies offset and floor.
// Every stage holds its beat when the stage after it is full and stalled, so
// back-pressure on the output stalls only as far back as needed. Configuration
// writes are always taken; write them only while no sample is in flight.
// ----------------------------------------------------------------------------
module trace_log_level_converter_top import tllc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tllc_sample_if.sink       samp_i,
  tllc_level_if.source      lvl_o,
  tllc_cfg_if.sink          cfg_i
);

  cfg_t   cfg_q;
  logic   fr_valid, fr_ready;
  prod_t  fr_data;
  logic   nm_valid, nm_ready;
  norm_t  nm_data;
  logic   pl_valid, pl_ready;
  lvl_t   pl_data;

  logic                     out_v_q;
  logic signed [LevelW-1:0] out_level_q;
  logic signed [LevelW:0]   offs_sum;
  logic signed [LevelW-1:0] sat_level;
  logic signed [LevelW-1:0] level_d;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.recip_scale   <= RecipReset;
      cfg_q.concat_enable <= 1'b0;
      cfg_q.join_point    <= '0;
      cfg_q.low_offset    <= '0;
      cfg_q.min_level     <= LevelMin;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CfgRecipScale:   cfg_q.recip_scale   <= cfg_i.data[ScaleW-1:0];
        CfgConcatEnable: cfg_q.concat_enable <= cfg_i.data[0];
        CfgJoinPoint:    cfg_q.join_point    <= cfg_i.data[IndexW-1:0];
        CfgLowOffset:    cfg_q.low_offset    <= $signed(cfg_i.data[LevelW-1:0]);
        CfgMinLevel:     cfg_q.min_level     <= $signed(cfg_i.data[LevelW-1:0]);
        default: ;
      endcase
    end
  end

  tllc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (samp_i.valid),
    .in_ready_o     (samp_i.ready),
    .sample_index_i (samp_i.sample_index),
    .high_sample_i  (samp_i.high_sample),
    .low_sample_i   (samp_i.low_sample),
    .out_valid_o    (fr_valid),
    .out_ready_i    (fr_ready),
    .out_o          (fr_data)
  );

  tllc_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_i        (fr_data),
    .out_valid_o (nm_valid),
    .out_ready_i (nm_ready),
    .out_o       (nm_data)
  );

  tllc_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (nm_valid),
    .in_ready_o  (nm_ready),
    .in_i        (nm_data),
    .out_valid_o (pl_valid),
    .out_ready_i (pl_ready),
    .out_o       (pl_data)
  );

  // Offset for the low-power part, saturate, then floor
  always_comb begin
    offs_sum = (LevelW+1)'(pl_data.level)
             + (pl_data.use_low ? (LevelW+1)'(cfg_q.low_offset) : '0);
    if (offs_sum[LevelW] != offs_sum[LevelW-1]) begin
      sat_level = offs_sum[LevelW] ? LevelMin : LevelMax;
    end else begin
      sat_level = offs_sum[LevelW-1:0];
    end
    level_d = (sat_level < cfg_q.min_level) ? cfg_q.min_level : sat_level;
  end

  // Output register
  assign pl_ready = !out_v_q || lvl_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (pl_ready) begin
      out_v_q <= pl_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pl_ready && pl_valid) out_level_q <= level_d;
  end

  assign lvl_o.valid = out_v_q;
  assign lvl_o.level = out_level_q;

endmodule
`default_nettype wire
